[design/dmwc_pkg.sv]
// ----------------------------------------------------------------------------
// dmwc_pkg : shared constants and types for the direct-mapped write-back cache
// Address split, memory sizes, sequencer phase codes and control structs.
// ----------------------------------------------------------------------------
package dmwc_pkg;

    localparam int LINE_COUNT     = 64;
    localparam int WORDS_PER_LINE = 4;
    localparam int WORD_BITS      = 32;
    localparam int ADDRESS_BITS   = 16;

    localparam int OFF_BITS  = $clog2(WORDS_PER_LINE);
    localparam int IDX_BITS  = $clog2(LINE_COUNT);
    localparam int ROW_BITS  = OFF_BITS + IDX_BITS;
    localparam int TAG_BITS  = ADDRESS_BITS - ROW_BITS;
    localparam int STEP_BITS = $clog2(WORDS_PER_LINE + 1);

    localparam int LINE_WORDS = LINE_COUNT * WORDS_PER_LINE;
    localparam int MEM_DEPTH  = 1 << ADDRESS_BITS;

    // sequencer phases
    localparam int PH_BITS = 3;
    localparam logic [PH_BITS-1:0] PH_CLEAR  = 3'd0;
    localparam logic [PH_BITS-1:0] PH_IDLE   = 3'd1;
    localparam logic [PH_BITS-1:0] PH_LOOKUP = 3'd2;
    localparam logic [PH_BITS-1:0] PH_WBACK  = 3'd3;
    localparam logic [PH_BITS-1:0] PH_FILL   = 3'd4;

    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(WORDS_PER_LINE);

    // lookup outcome, datapath -> sequencer
    typedef struct packed {
        logic hit;
        logic victim_dirty;
    } t_look;

    // sequencer state, sequencer -> datapath
    typedef struct packed {
        logic [PH_BITS-1:0]      phase;
        logic [STEP_BITS-1:0]    step;
        logic                    last;
        logic [ADDRESS_BITS-1:0] clr_addr;
    } t_seq;

endpackage

[design/dmwc_ram.sv]
// ----------------------------------------------------------------------------
// dmwc_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/dmwc_seq.sv]
// ----------------------------------------------------------------------------
// dmwc_seq : request sequencer
// Phase machine, word step counter and the post-reset clearing counter.
// ----------------------------------------------------------------------------
module dmwc_seq
    import dmwc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_look i_look,
    output t_seq  o_seq
);

    logic [PH_BITS-1:0]      r_phase, n_phase;
    logic [STEP_BITS-1:0]    r_step, n_step;
    logic [ADDRESS_BITS-1:0] r_clr_addr;
    logic                    last;

    assign last = (r_step == STEP_LAST);

    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        case (r_phase)
            PH_CLEAR: begin
                if (&r_clr_addr) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_IDLE: begin
                if (i_accept) begin
                    n_phase = PH_LOOKUP;
                end
            end
            PH_LOOKUP: begin
                n_step = '0;
                if (i_look.hit) begin
                    n_phase = PH_IDLE;
                end else if (i_look.victim_dirty) begin
                    n_phase = PH_WBACK;
                end else begin
                    n_phase = PH_FILL;
                end
            end
            PH_WBACK: begin
                if (last) begin
                    n_phase = PH_FILL;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            PH_FILL: begin
                if (last) begin
                    n_phase = PH_IDLE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CLEAR;
            r_step     <= '0;
            r_clr_addr <= '0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            if (r_phase == PH_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_seq.phase    = r_phase;
    assign o_seq.step     = r_step;
    assign o_seq.last     = last;
    assign o_seq.clr_addr = r_clr_addr;

endmodule

[design/direct_mapped_writeback_cache.sv]
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache : direct-mapped write-back write-allocate cache
// 64 lines x 4 words in front of a 64K-word backing memory held inside.
// ----------------------------------------------------------------------------
// A request (read or write of one word) is taken on a clock edge where start
// is high and busy is low. Exactly one result follows: o_done is high for one
// cycle with o_hit, o_read_data (the addressed word after the access) and
// o_wrote_back. The receiver cannot stall; it must take the result in that
// cycle. The result appears in the cycle in which busy first allows the
// following request. The miss cost is set by the line and backing RAMs
// moving one word per cycle through their single write port, plus the
// registered read of each block move. After reset the block clears the
// backing memory one word per cycle and holds busy high for that pass.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache
    import dmwc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_operation,
    input  logic [ADDRESS_BITS-1:0] i_address,
    input  logic [WORD_BITS-1:0]    i_write_data,
    output logic                    o_done,
    output logic                    o_hit,
    output logic [WORD_BITS-1:0]    o_read_data,
    output logic                    o_wrote_back
);

    // ---------------- request capture ----------------
    logic                    accept;
    logic                    r_op;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [WORD_BITS-1:0]    r_wdata;

    logic [OFF_BITS-1:0] r_off;
    logic [IDX_BITS-1:0] r_idx;
    logic [TAG_BITS-1:0] r_tag;
    logic [IDX_BITS-1:0] idx_in;
    logic [ROW_BITS-1:0] row_in;

    assign r_off  = r_addr[OFF_BITS-1:0];
    assign r_idx  = r_addr[ROW_BITS-1:OFF_BITS];
    assign r_tag  = r_addr[ADDRESS_BITS-1:ROW_BITS];
    assign idx_in = i_address[ROW_BITS-1:OFF_BITS];
    assign row_in = i_address[ROW_BITS-1:0];

    // ---------------- sequencer ----------------
    t_seq  seq;
    t_look look;

    dmwc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_look   (look),
        .o_seq    (seq)
    );

    assign busy   = (seq.phase != PH_IDLE);
    assign accept = start && !busy;

    // word being read this step, and word whose read data lands this step
    logic [STEP_BITS-1:0] step_m1;
    logic [OFF_BITS-1:0]  rd_word;
    logic [OFF_BITS-1:0]  wr_word;
    logic                 step_wr;

    assign step_m1 = seq.step - 1'b1;
    assign rd_word = seq.step[OFF_BITS-1:0];
    assign wr_word = step_m1[OFF_BITS-1:0];
    assign step_wr = (seq.step != '0);

    // ---------------- line state ----------------
    logic [LINE_COUNT-1:0] r_valid;
    logic [LINE_COUNT-1:0] r_dirty;
    logic [TAG_BITS-1:0]   r_vtag;
    logic [TAG_BITS-1:0]   tag_rdata;
    logic                  tag_we;

    assign look.hit          = r_valid[r_idx] && (tag_rdata == r_tag);
    assign look.victim_dirty = r_valid[r_idx] && r_dirty[r_idx];

    assign tag_we = (seq.phase == PH_FILL) && seq.last;

    dmwc_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (LINE_COUNT)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_idx),
        .i_wdata (r_tag),
        .i_raddr ((seq.phase == PH_IDLE) ? idx_in : r_idx),
        .o_rdata (tag_rdata)
    );

    // ---------------- line data RAM ----------------
    logic                 lookup_wr_hit;
    logic                 line_we;
    logic [ROW_BITS-1:0]  line_waddr;
    logic [ROW_BITS-1:0]  line_raddr;
    logic [WORD_BITS-1:0] line_wdata;
    logic [WORD_BITS-1:0] line_rdata;
    logic [WORD_BITS-1:0] back_rdata;
    logic [WORD_BITS-1:0] fill_word;

    assign lookup_wr_hit = (seq.phase == PH_LOOKUP) && look.hit && r_op;

    // the new word of a write miss replaces the fetched one as it lands
    assign fill_word = (r_op && (wr_word == r_off)) ? r_wdata : back_rdata;

    always_comb begin
        case (seq.phase)
            PH_IDLE:  line_raddr = row_in;
            PH_WBACK: line_raddr = {r_idx, rd_word};
            default:  line_raddr = {r_idx, r_off};
        endcase
    end

    assign line_we    = lookup_wr_hit || ((seq.phase == PH_FILL) && step_wr);
    assign line_waddr = (seq.phase == PH_FILL) ? {r_idx, wr_word} : {r_idx, r_off};
    assign line_wdata = (seq.phase == PH_FILL) ? fill_word : r_wdata;

    dmwc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (LINE_WORDS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (line_wdata),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    // ---------------- backing memory ----------------
    // clearing pass after reset, victim write-back on a dirty miss
    logic                    back_we;
    logic [ADDRESS_BITS-1:0] back_waddr;
    logic [WORD_BITS-1:0]    back_wdata;

    assign back_we    = (seq.phase == PH_CLEAR) || ((seq.phase == PH_WBACK) && step_wr);
    assign back_waddr = (seq.phase == PH_CLEAR) ? seq.clr_addr : {r_vtag, r_idx, wr_word};
    assign back_wdata = (seq.phase == PH_CLEAR) ? '0 : line_rdata;

    dmwc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (back_we),
        .i_waddr (back_waddr),
        .i_wdata (back_wdata),
        .i_raddr ({r_tag, r_idx, rd_word}),
        .o_rdata (back_rdata)
    );

    // ---------------- registers ----------------
    logic                 r_done;
    logic                 r_hit;
    logic [WORD_BITS-1:0] r_read_data;
    logic                 r_wrote_back;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= ((seq.phase == PH_LOOKUP) && look.hit)
                   || ((seq.phase == PH_FILL) && seq.last);
            if (lookup_wr_hit) begin
                r_dirty[r_idx] <= 1'b1;
            end
            if (tag_we) begin
                r_valid[r_idx] <= 1'b1;
                r_dirty[r_idx] <= r_op;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (seq.phase == PH_LOOKUP) begin
            r_vtag       <= tag_rdata;
            r_hit        <= look.hit;
            r_wrote_back <= !look.hit && look.victim_dirty;
            if (look.hit) begin
                r_read_data <= r_op ? r_wdata : line_rdata;
            end
        end
        if ((seq.phase == PH_FILL) && step_wr && (wr_word == r_off)) begin
            r_read_data <= fill_word;
        end
    end

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_read_data  = r_read_data;
    assign o_wrote_back = r_wrote_back;

    // ---------------- assertions ----------------
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (seq.phase == PH_LOOKUP))
        else $error("accepted request did not enter lookup");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(seq.phase) == PH_LOOKUP) || ($past(seq.phase) == PH_FILL))
        else $error("result strobe without lookup or fill");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_wrote_back) |-> !o_hit)
        else $error("write-back reported on a hit");

endmodule
